### rtl/binary_min_heap_queue_assert.svh
// Assertion macros for the priority queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, skipped while reset is high.
`define BMHQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on the rising clock edge, reset included.
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMHQ_ASSERT(label, clk, rst, prop, msg)
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/bmhq_pkg.sv
// Shared types and codes of the priority queue.
package bmhq_pkg;

   localparam int KEY_W = 32;
   localparam int FILL_W = 8;
   localparam int STATUS_W = 2;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic                    action;
      logic signed [KEY_W-1:0] key_in;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] min_out;
      logic [STATUS_W-1:0]     status;
      logic [FILL_W-1:0]       fill_count;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                    insert;
      logic                    extract;
      logic signed [KEY_W-1:0] key;
   } ctrl_type;

endpackage

### rtl/bmhq_cell.sv
// One cell of the sorted key chain: holds one key and trades with its neighbors.
module bmhq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 8
) (
   input  logic                             clock,
   input  bmhq_pkg::ctrl_type               ctrl,
   input  logic [CNT_W-1:0]                 count,
   input  logic signed [bmhq_pkg::KEY_W-1:0] left_val,
   input  logic                             left_gt,
   input  logic signed [bmhq_pkg::KEY_W-1:0] right_val,
   output logic signed [bmhq_pkg::KEY_W-1:0] val,
   output logic                             gt
);

   logic signed [bmhq_pkg::KEY_W-1:0] val_ff;
   logic signed [bmhq_pkg::KEY_W-1:0] val_in;
   logic                              occupied;

   assign occupied = (count > CNT_W'(INDEX));
   // An empty slot counts as larger than any key.
   assign gt = !occupied || (val_ff > ctrl.key);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.insert) begin
         if (gt) begin
            val_in = left_gt ? left_val : ctrl.key;
         end
      end else if (ctrl.extract) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### rtl/binary_min_heap_queue.sv
// Priority queue of signed keys: a row of sorted cells, smallest key in cell 0.
// The result is registered and valid the cycle after a request is taken;
// one request per cycle while rsp_ready keeps pace. Every cell compares with
// the broadcast key and shifts at once, so fill level does not limit the rate.
// Reset (synchronous, active high) empties the queue and drops any pending result.
`include "binary_min_heap_queue_assert.svh"
module binary_min_heap_queue #(
   parameter int CAPACITY = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmhq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmhq_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   bmhq_pkg::rsp_type                 rsp_ff;
   bmhq_pkg::rsp_type                 rsp_in;
   bmhq_pkg::ctrl_type                ctrl;
   logic                              accept;
   logic                              full;
   logic                              empty;
   logic signed [bmhq_pkg::KEY_W-1:0] vals [CAPACITY];
   logic                              gts  [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign full = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      ctrl.insert = accept && (req_payload.action == bmhq_pkg::ACT_INSERT) && !full;
      ctrl.extract = accept && (req_payload.action == bmhq_pkg::ACT_EXTRACT) && !empty;
      ctrl.key = req_payload.key_in;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.extract) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in.min_out = '0;
      rsp_in.status = bmhq_pkg::ST_OK;
      rsp_in.fill_count = bmhq_pkg::FILL_W'(count_in);
      if (req_payload.action == bmhq_pkg::ACT_INSERT) begin
         if (full) begin
            rsp_in.status = bmhq_pkg::ST_FULL;
         end
      end else if (empty) begin
         rsp_in.status = bmhq_pkg::ST_EMPTY;
      end else begin
         rsp_in.min_out = vals[0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [bmhq_pkg::KEY_W-1:0] left_val;
      logic                              left_gt;
      logic signed [bmhq_pkg::KEY_W-1:0] right_val;

      if (i == 0) begin : g_head
         assign left_val = '0;
         assign left_gt = 1'b0;
      end else begin : g_body
         assign left_val = vals[i-1];
         assign left_gt = gts[i-1];
      end

      // The last cell holds on extract; its slot is vacated by the count.
      if (i == CAPACITY - 1) begin : g_tail
         assign right_val = vals[i];
      end else begin : g_mid
         assign right_val = vals[i+1];
      end

      bmhq_cell #(
         .INDEX(i),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count_ff),
         .left_val (left_val),
         .left_gt  (left_gt),
         .right_val(right_val),
         .val      (vals[i]),
         .gt       (gts[i])
      );
   end

   `BMHQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `BMHQ_ASSERT(a_head_sorted, clock, reset, (count_ff >= CNT_W'(2)) |-> (vals[0] <= vals[1]), "head cells out of order")
   `BMHQ_ASSERT(a_insert_count, clock, reset, ctrl.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not grow count")
   `BMHQ_ASSERT(a_empty_status, clock, reset, (accept && empty && (req_payload.action == bmhq_pkg::ACT_EXTRACT)) |=> (rsp_valid_ff && (rsp_ff.status == bmhq_pkg::ST_EMPTY)), "empty extract not flagged")

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the priority queue: directed and random requests against a heap model.
module tb;

   localparam int QUEUE_DEPTH = 128;
   localparam int IDLE_PCT = 35;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 20;

   class heap_scoreboard;
      logic signed [bmhq_pkg::KEY_W-1:0] slots [QUEUE_DEPTH];
      int held;
      bmhq_pkg::rsp_type expected_q [$];
      int errors;
      int inserts;
      int extracts;
      int empty_hits;
      int full_hits;
      int peak_fill;

      function new();
         held = 0;
         errors = 0;
         inserts = 0;
         extracts = 0;
         empty_hits = 0;
         full_hits = 0;
         peak_fill = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Update the heap for one accepted request and queue its result.
      function void note_request(bmhq_pkg::req_type r);
         bmhq_pkg::rsp_type want;
         logic signed [bmhq_pkg::KEY_W-1:0] tmp;
         int pos;
         int up;
         int kid;
         want.min_out = '0;
         want.status = bmhq_pkg::ST_OK;
         if (r.action == bmhq_pkg::ACT_INSERT) begin
            inserts++;
            if (held >= QUEUE_DEPTH) begin
               want.status = bmhq_pkg::ST_FULL;
               full_hits++;
            end else begin
               slots[held] = r.key_in;
               pos = held;
               held++;
               while (pos > 0) begin
                  up = (pos - 1) / 2;
                  if (slots[up] <= slots[pos])
                     break;
                  tmp = slots[up];
                  slots[up] = slots[pos];
                  slots[pos] = tmp;
                  pos = up;
               end
            end
         end else begin
            extracts++;
            if (held == 0) begin
               want.status = bmhq_pkg::ST_EMPTY;
               empty_hits++;
            end else begin
               want.min_out = slots[0];
               held--;
               slots[0] = slots[held];
               pos = 0;
               kid = 1;
               while (kid < held) begin
                  // ties go to the left child
                  if (kid + 1 < held && slots[kid + 1] < slots[kid])
                     kid = kid + 1;
                  if (slots[pos] < slots[kid])
                     break;
                  tmp = slots[kid];
                  slots[kid] = slots[pos];
                  slots[pos] = tmp;
                  pos = kid;
                  kid = 2 * pos + 1;
               end
            end
         end
         want.fill_count = bmhq_pkg::FILL_W'(held);
         if (held > peak_fill)
            peak_fill = held;
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_result(bmhq_pkg::rsp_type got);
         bmhq_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with no request pending: min_out %0d status %0d",
                                      got.min_out, got.status));
            return;
         end
         want = expected_q.pop_front();
         if (got.min_out !== want.min_out)
            report_mismatch($sformatf("min_out got %0d want %0d", got.min_out, want.min_out));
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count got %0d want %0d",
                                      got.fill_count, want.fill_count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bmhq_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bmhq_pkg::rsp_type rsp_payload;

   heap_scoreboard sb;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   int stalled_cycles = 0;

   binary_min_heap_queue #(
      .CAPACITY(QUEUE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Note requests before results so a same-edge pair stays ordered.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_payload);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result side: random stalls, a stretch with no stalls, and one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic logic signed [bmhq_pkg::KEY_W-1:0] random_key();
      case ($urandom_range(9))
         6, 7: return bmhq_pkg::KEY_W'(int'($urandom_range(16)) - 8);
         8: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return '0;
               default: return '1;
            endcase
         end
         9: return 32'sh7FFF_FFF0 + $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Offer one request after a random gap (none in steady mode) and hold it until accepted.
   task send_request(logic act, logic signed [bmhq_pkg::KEY_W-1:0] key);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(99) < IDLE_PCT)
            gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload.action <= act;
      req_payload.key_in <= key;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task run_phase(int count, int insert_pct);
      repeat (count)
         send_request(($urandom_range(99) < insert_pct) ? bmhq_pkg::ACT_INSERT
                                                        : bmhq_pkg::ACT_EXTRACT,
                      random_key());
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty extract, key extremes, duplicates, drain back to empty
      send_request(bmhq_pkg::ACT_EXTRACT, 32'sh7FFF_FFFF);
      send_request(bmhq_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
      send_request(bmhq_pkg::ACT_INSERT, 32'sh8000_0000);
      send_request(bmhq_pkg::ACT_INSERT, 32'sh0000_0000);
      send_request(bmhq_pkg::ACT_INSERT, -32'sd1);
      send_request(bmhq_pkg::ACT_INSERT, 32'sd7);
      send_request(bmhq_pkg::ACT_INSERT, 32'sd7);
      send_request(bmhq_pkg::ACT_INSERT, 32'sd7);
      send_request(bmhq_pkg::ACT_INSERT, 32'sd1);
      repeat (8) send_request(bmhq_pkg::ACT_EXTRACT, random_key());
      send_request(bmhq_pkg::ACT_EXTRACT, 32'sh8000_0000);
      send_request(bmhq_pkg::ACT_INSERT, 32'sd42);
      send_request(bmhq_pkg::ACT_EXTRACT, '1);
      send_request(bmhq_pkg::ACT_EXTRACT, '0);

      run_phase(200, 55);

      // hold results back for a stretch, then fill past capacity
      hold_request = 1'b1;
      run_phase(160, 95);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);

      run_phase(160, 5);

      steady = 1'b1;
      run_phase(150, 50);
      steady = 1'b0;
      run_phase(80, 50);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d inserts and %0d extracts, peak fill %0d of %0d",
               sb.inserts, sb.extracts, sb.peak_fill, QUEUE_DEPTH);
      $display("Errors exercised: %0d extracts from empty, %0d inserts dropped when full",
               sb.empty_hits, sb.full_hits);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### binary_min_heap_queue.f
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_cell.sv
rtl/binary_min_heap_queue.sv
bench/tb.sv
